// ===== rtl/core/length_prefix_deframer_top_assert.svh =====
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIX_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_TOP_ASSERT_SVH

// Property that must hold in the same cycle as its antecedent.
`define LPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== rtl/core/lpd_pkg.sv =====
// Shared types and constants of the length-prefix deframer.
package lpd_pkg;

  localparam int unsigned HEADER_BYTES = 2;

  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [14:0] MAX_LEN_RESET = 15'd2048;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/lpd_parser.sv =====
// Header and body parsing state of the deframer, one stream byte per cycle while step_i is high.
module lpd_parser import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_max_len_i,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        abort_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_HALTED = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic        hdr_seen_q, hdr_seen_d;
  logic [7:0]  hdr_low_q, hdr_low_d;
  logic [14:0] remain_q, remain_d;
  logic [14:0] max_len_q;
  logic [15:0] raw_len;
  logic [14:0] remain_dec;
  logic        halted;

  assign halted     = (phase_q != PH_HEADER) && (phase_q != PH_BODY);
  assign raw_len    = {data_byte_i, hdr_low_q};
  assign remain_dec = (remain_q != 15'd0) ? remain_q - 15'd1 : remain_q;

  always_comb begin
    phase_d     = phase_q;
    hdr_seen_d  = hdr_seen_q;
    hdr_low_d   = hdr_low_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i && !halted) begin
      if (abort_i) begin
        phase_d     = PH_HALTED;
        res_valid_o = 1'b1;
        res_o.kind  = KIND_ERROR;
      end else if (phase_q == PH_HEADER) begin
        if (hdr_seen_q != 1'(HEADER_BYTES - 1)) begin
          hdr_low_d  = data_byte_i;
          hdr_seen_d = 1'b1;
        end else begin
          hdr_seen_d = 1'b0;
          // Bit 15 set is a negative length.
          if (raw_len[15] || (raw_len[14:0] > max_len_q)) begin
            phase_d     = PH_HALTED;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
          end else if (raw_len == 16'd0) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_EMPTY;
            res_o.last  = 1'b1;
          end else begin
            remain_d = raw_len[14:0];
            phase_d  = PH_BODY;
          end
        end
      end else begin
        remain_d      = remain_dec;
        res_valid_o   = 1'b1;
        res_o.kind    = KIND_BODY;
        res_o.payload = data_byte_i;
        if (remain_dec == 15'd0) begin
          res_o.last = 1'b1;
          phase_d    = PH_HEADER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_seen_q <= 1'b0;
      hdr_low_q  <= 8'd0;
      remain_q   <= 15'd0;
      max_len_q  <= MAX_LEN_RESET;
    end else begin
      phase_q    <= phase_d;
      hdr_seen_q <= hdr_seen_d;
      hdr_low_q  <= hdr_low_d;
      remain_q   <= remain_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_max_len_i;
      end
    end
  end

endmodule

// ===== rtl/core/lpd_out_buf.sv =====
// Two-entry output register with skid stage for deframer results.
module lpd_out_buf import lpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_res_i,
  output logic space_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic main_valid_q, skid_valid_q;
  res_t main_q, skid_q;
  logic pop;

  assign pop         = main_valid_q && out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_res_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_q <= skid_valid_q ? skid_q : push_res_i;
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= push_res_i;
      end else begin
        main_q <= push_res_i;
      end
    end
  end

endmodule

// ===== rtl/core/length_prefix_deframer_top.sv =====
// Top level of the length-prefix deframer.
// The block splits a received byte stream into messages. Each message is a
// two-byte little-endian header holding a signed 16-bit body length, then
// that many body bytes. One stream byte enters per input transaction
// (data_byte_i, abort_i on in_valid_i / in_ready_o).
// Each body byte leaves as one output transaction with result_kind_o body,
// and last_of_message_o marks the final byte. A zero-length header gives one
// empty-message transaction. A negative length, a length above the
// configured maximum, or abort_i gives one error transaction, after which
// every input is taken and dropped until reset. Header bytes otherwise give
// no output.
// The maximum body length is written through cfg_valid_i / cfg_ready_o.
// The user must write it only while the block is idle; the block does not
// enforce this. cfg_ready_o is always high. A result is registered in the
// output buffer before it appears on the output. Throughput: one byte per
// cycle while in_ready_o is high, set by the single parse stage between the
// input handshake and the output register. The two-entry output buffer keeps
// input flowing after the receiver stalls until a result needs its skid
// entry; in_ready_o drops once that entry is in use. Reset clears the parse
// state, sets the maximum to 2048 and empties the output buffer.
module length_prefix_deframer_top import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_max_body_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        abort_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_message_o
);

  logic step;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_i && in_ready_o;

  lpd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_max_len_i (cfg_max_body_length_i),
    .step_i        (step),
    .data_byte_i   (data_byte_i),
    .abort_i       (abort_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  lpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_res_i  (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign result_kind_o     = out_res.kind;
  assign payload_byte_o    = out_res.payload;
  assign last_of_message_o = out_res.last;

endmodule

// ===== rtl/core/lpd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
`include "length_prefix_deframer_top_assert.svh"

module lpd_checker import lpd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic        last_of_message_o
);

  logic        out_stall;
  logic [10:0] out_bus;
  logic        non_body;
  logic        last_ok;
  logic        err_take;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_bus   = {result_kind_o, payload_byte_o, last_of_message_o};
  assign non_body  = out_valid_o && (result_kind_o != KIND_BODY);
  assign last_ok   = (last_of_message_o == (result_kind_o == KIND_EMPTY));
  assign err_take  = out_valid_o && out_ready_i && (result_kind_o == KIND_ERROR);

  // A stalled result holds.
  `LPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_bus))

  // Only body results carry a byte.
  `LPD_ASSERT(a_payload_zero, clk_i, rst_ni, !non_body || (payload_byte_o == 8'd0))

  // An empty message always closes a message; an error never does.
  `LPD_ASSERT(a_last_flag, clk_i, rst_ni, !non_body || last_ok)

  // The error is the final result of a session.
  `LPD_ASSERT_NEXT(a_error_final, clk_i, rst_ni, err_take, !out_valid_o)

endmodule

bind length_prefix_deframer_top lpd_checker u_lpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .result_kind_o     (result_kind_o),
  .payload_byte_o    (payload_byte_o),
  .last_of_message_o (last_of_message_o)
);
